// File: design/sorted_priority_queue_top_macros.svh
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SPQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("spq assertion failed");
`define SPQ_ASSERT_NEXT(lbl, clk, rst, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("spq assertion failed");
`else
`define SPQ_ASSERT(lbl, clk, rst, prop)
`define SPQ_ASSERT_NEXT(lbl, clk, rst, cond, conseq)
`endif

`endif

// File: design/spq_pkg.sv
package spq_pkg;

  localparam int COUNT_W = 5;
  localparam int LIMIT_W = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef struct packed {
    logic valid;
    logic is_push;
  } spq_req_ctl_t;

endpackage

// File: design/sorted_priority_queue_top.sv
// An accepted request waits in a short input queue that parts intake from the cell
// array; its result is then registered in the output register.
// Throughput: one request per cycle while out_stall does not hold the output.
// Each push or pop that is not rejected updates all slot cells in parallel.
// Reset (rst, synchronous): queue emptied, limit set to 16, slot contents left as is.
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 16,
  parameter int TAG_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic [PRIO_BITS-1:0] entry_priority,
  input  logic [TAG_BITS-1:0]  task_tag,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic                 head_valid,
  output logic [PRIO_BITS-1:0] head_priority,
  output logic [TAG_BITS-1:0]  head_tag,
  output logic [COUNT_W-1:0]   entry_count,
  output logic                 full_flag,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LIMIT_W-1:0]   queue_limit
);

  spq_req_ctl_t         req_ctl;
  logic [PRIO_BITS-1:0] req_priority;
  logic [TAG_BITS-1:0]  req_tag;
  logic                 req_take;
  logic [LIMIT_W-1:0]   limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= queue_limit;
    end
  end

  spq_front #(
    .PRIO_BITS(PRIO_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .entry_priority(entry_priority),
    .task_tag      (task_tag),
    .req_ctl       (req_ctl),
    .req_priority  (req_priority),
    .req_tag       (req_tag),
    .req_take      (req_take)
  );

  spq_back #(
    .DEPTH    (DEPTH),
    .PRIO_BITS(PRIO_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .req_ctl      (req_ctl),
    .req_priority (req_priority),
    .req_tag      (req_tag),
    .req_take     (req_take),
    .queue_limit  (limit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .head_valid   (head_valid),
    .head_priority(head_priority),
    .head_tag     (head_tag),
    .entry_count  (entry_count),
    .full_flag    (full_flag)
  );

endmodule

// File: design/spq_front.sv
module spq_front import spq_pkg::*; #(
  parameter int PRIO_BITS = 16,
  parameter int TAG_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic [PRIO_BITS-1:0] entry_priority,
  input  logic [TAG_BITS-1:0]  task_tag,
  output spq_req_ctl_t         req_ctl,
  output logic [PRIO_BITS-1:0] req_priority,
  output logic [TAG_BITS-1:0]  req_tag,
  input  logic                 req_take
);

  logic [1:0]           used;
  logic [1:0]           used_next;
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic                 push_q [2];
  logic [PRIO_BITS-1:0] prio_q [2];
  logic [TAG_BITS-1:0]  tag_q  [2];
  logic                 acc;

  assign in_stall = (used == 2'd2);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    used_next = used;
    if (acc && !req_take) begin
      used_next = used + 2'd1;
    end else if (!acc && req_take) begin
      used_next = used - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      used <= used_next;
      if (acc) begin
        wr_ptr <= !wr_ptr;
      end
      if (req_take) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  // classify on entry
  always_ff @(posedge clk) begin
    if (acc) begin
      push_q[wr_ptr] <= (kind == KIND_PUSH);
      prio_q[wr_ptr] <= entry_priority;
      tag_q[wr_ptr]  <= task_tag;
    end
  end

  assign req_ctl.valid   = (used != 2'd0);
  assign req_ctl.is_push = push_q[rd_ptr];
  assign req_priority    = prio_q[rd_ptr];
  assign req_tag         = tag_q[rd_ptr];

endmodule

// File: design/spq_back.sv
`include "sorted_priority_queue_top_macros.svh"

module spq_back import spq_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 16,
  parameter int TAG_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  spq_req_ctl_t         req_ctl,
  input  logic [PRIO_BITS-1:0] req_priority,
  input  logic [TAG_BITS-1:0]  req_tag,
  output logic                 req_take,
  input  logic [LIMIT_W-1:0]   queue_limit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic                 head_valid,
  output logic [PRIO_BITS-1:0] head_priority,
  output logic [TAG_BITS-1:0]  head_tag,
  output logic [COUNT_W-1:0]   entry_count,
  output logic                 full_flag
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [PRIO_BITS-1:0] slot_p [DEPTH];
  logic [TAG_BITS-1:0]  slot_t [DEPTH];
  logic [PRIO_BITS-1:0] p_next [DEPTH];
  logic [TAG_BITS-1:0]  t_next [DEPTH];
  logic [PRIO_BITS-1:0] prev_p [DEPTH];
  logic [TAG_BITS-1:0]  prev_t [DEPTH];
  logic [PRIO_BITS-1:0] nxt_p  [DEPTH];
  logic [TAG_BITS-1:0]  nxt_t  [DEPTH];
  logic [DEPTH-1:0]     le;
  logic [DEPTH-1:0]     le_prev;
  logic [31:0]          lim32;
  logic [31:0]          cn32;
  logic                 full_now;
  logic                 reject_full;
  logic                 reject_empty;
  logic                 reject;
  logic                 apply;
  logic [1:0]           status_next;

  assign req_take = req_ctl.valid && (!out_valid || !out_stall);

  assign lim32 = (32'(queue_limit) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(queue_limit);
  assign full_now     = 32'(count) >= lim32;
  assign reject_full  = req_ctl.is_push && full_now;
  assign reject_empty = !req_ctl.is_push && (count == '0);
  assign reject       = reject_full || reject_empty;
  assign apply        = req_take && !reject;

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    if (reject_full) begin
      status_next = ST_FULL;
    end else if (reject_empty) begin
      status_next = ST_EMPTY;
    end else if (req_ctl.is_push) begin
      count_next = count + CNT_W'(1);
    end else begin
      count_next = count - CNT_W'(1);
    end
  end

  assign cn32 = 32'(count_next);

  // each cell compares against the incoming priority; ties stay ahead
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (32'(i) < 32'(count)) && (slot_p[i] <= req_priority);
    end
    le_prev   = {le[DEPTH-2:0], 1'b1};
    prev_p[0] = req_priority;
    prev_t[0] = req_tag;
    for (int i = 1; i < DEPTH; i++) begin
      prev_p[i] = slot_p[i-1];
      prev_t[i] = slot_t[i-1];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      nxt_p[i] = slot_p[i+1];
      nxt_t[i] = slot_t[i+1];
    end
    nxt_p[DEPTH-1] = slot_p[DEPTH-1];
    nxt_t[DEPTH-1] = slot_t[DEPTH-1];
    for (int i = 0; i < DEPTH; i++) begin
      if (!req_ctl.is_push) begin
        p_next[i] = nxt_p[i];
        t_next[i] = nxt_t[i];
      end else if (le[i]) begin
        p_next[i] = slot_p[i];
        t_next[i] = slot_t[i];
      end else if (le_prev[i]) begin
        p_next[i] = req_priority;
        t_next[i] = req_tag;
      end else begin
        p_next[i] = prev_p[i];
        t_next[i] = prev_t[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_p[i] <= p_next[i];
        slot_t[i] <= t_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (req_take) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      status      <= status_next;
      entry_count <= cn32[COUNT_W-1:0];
      full_flag   <= cn32 >= lim32;
      if (count_next != '0) begin
        head_valid    <= 1'b1;
        head_priority <= apply ? p_next[0] : slot_p[0];
        head_tag      <= apply ? t_next[0] : slot_t[0];
      end else begin
        head_valid    <= 1'b0;
        head_priority <= '0;
        head_tag      <= '0;
      end
    end
  end

  `SPQ_ASSERT(a_count_bound, clk, rst, 32'(count) <= 32'(DEPTH))
  `SPQ_ASSERT_NEXT(a_reject_hold, clk, rst, req_take && reject, $stable(count))
  `SPQ_ASSERT_NEXT(a_pop_dec, clk, rst, req_take && !req_ctl.is_push && !reject, 32'(count) == 32'($past(count)) - 32'd1)
  `SPQ_ASSERT(a_head_order, clk, rst, (32'(count) >= 32'd2) |-> (slot_p[0] <= slot_p[1]))

endmodule

// File: dv/sorted_priority_queue_top_test.sv
`timescale 1ns / 100ps

module sorted_priority_queue_top_test;
  import spq_pkg::*;

  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 16;
  localparam int TAG_BITS  = 16;

  typedef struct packed {
    logic [1:0]           status;
    logic                 head_valid;
    logic [PRIO_BITS-1:0] head_priority;
    logic [TAG_BITS-1:0]  head_tag;
    logic [COUNT_W-1:0]   entry_count;
    logic                 full_flag;
  } head_report_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [LIMIT_W-1:0]   limit;
    logic                 op;
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
    logic                 typed;
    head_report_t         want;
  } stim_row_t;

  localparam head_report_t NO_REPORT = '0;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 kind;
  logic [PRIO_BITS-1:0] entry_priority;
  logic [TAG_BITS-1:0]  task_tag;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           status;
  logic                 head_valid;
  logic [PRIO_BITS-1:0] head_priority;
  logic [TAG_BITS-1:0]  head_tag;
  logic [COUNT_W-1:0]   entry_count;
  logic                 full_flag;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   queue_limit;

  // shadow copy of the queue contents
  logic [PRIO_BITS-1:0] shadow_prio [DEPTH];
  logic [TAG_BITS-1:0]  shadow_tag [DEPTH];
  int                   shadow_count;
  logic [LIMIT_W-1:0]   shadow_limit;

  head_report_t head_reports [$];
  int           fail_count;
  int           hold_reqs;
  logic         typed_pending;
  head_report_t typed_report;

  stim_row_t directed_rows [25] = '{
    '{1'b0, 5'd0,  KIND_POP,  16'h0,    16'h0,    1'b1, '{ST_EMPTY, 1'b0, 16'h0, 16'h0, 5'd0, 1'b0}},
    '{1'b0, 5'd0,  KIND_PUSH, 16'hffff, 16'hffff, 1'b1,
      '{ST_DONE, 1'b1, 16'hffff, 16'hffff, 5'd1, 1'b0}},
    '{1'b0, 5'd0,  KIND_PUSH, 16'h0,    16'h0,    1'b1, '{ST_DONE, 1'b1, 16'h0, 16'h0, 5'd2, 1'b0}},
    '{1'b0, 5'd0,  KIND_PUSH, 16'h0,    16'h1,    1'b1, '{ST_DONE, 1'b1, 16'h0, 16'h0, 5'd3, 1'b0}},
    '{1'b0, 5'd0,  KIND_PUSH, 16'h8000, 16'h1234, 1'b0, NO_REPORT},
    '{1'b0, 5'd0,  KIND_POP,  16'h0,    16'h0,    1'b1, '{ST_DONE, 1'b1, 16'h0, 16'h1, 5'd3, 1'b0}},
    '{1'b0, 5'd0,  KIND_POP,  16'h0,    16'h0,    1'b1,
      '{ST_DONE, 1'b1, 16'h8000, 16'h1234, 5'd2, 1'b0}},
    '{1'b0, 5'd0,  KIND_POP,  16'h0,    16'h0,    1'b0, NO_REPORT},
    '{1'b0, 5'd0,  KIND_POP,  16'h0,    16'h0,    1'b1, '{ST_DONE, 1'b0, 16'h0, 16'h0, 5'd0, 1'b0}},
    '{1'b0, 5'd0,  KIND_POP,  16'h0,    16'h0,    1'b1, '{ST_EMPTY, 1'b0, 16'h0, 16'h0, 5'd0, 1'b0}},
    '{1'b1, 5'd1,  KIND_PUSH, 16'h0,    16'h0,    1'b0, NO_REPORT},
    '{1'b0, 5'd0,  KIND_PUSH, 16'h5,    16'haaaa, 1'b1,
      '{ST_DONE, 1'b1, 16'h5, 16'haaaa, 5'd1, 1'b1}},
    '{1'b0, 5'd0,  KIND_PUSH, 16'h3,    16'h5555, 1'b1,
      '{ST_FULL, 1'b1, 16'h5, 16'haaaa, 5'd1, 1'b1}},
    '{1'b1, 5'd0,  KIND_PUSH, 16'h0,    16'h0,    1'b0, NO_REPORT},
    '{1'b0, 5'd0,  KIND_PUSH, 16'h1,    16'h1,    1'b1,
      '{ST_FULL, 1'b1, 16'h5, 16'haaaa, 5'd1, 1'b1}},
    '{1'b0, 5'd0,  KIND_POP,  16'h0,    16'h0,    1'b1, '{ST_DONE, 1'b0, 16'h0, 16'h0, 5'd0, 1'b1}},
    '{1'b0, 5'd0,  KIND_PUSH, 16'h7,    16'h7,    1'b1, '{ST_FULL, 1'b0, 16'h0, 16'h0, 5'd0, 1'b1}},
    '{1'b0, 5'd0,  KIND_POP,  16'h0,    16'h0,    1'b1, '{ST_EMPTY, 1'b0, 16'h0, 16'h0, 5'd0, 1'b1}},
    '{1'b1, 5'd31, KIND_PUSH, 16'h0,    16'h0,    1'b0, NO_REPORT},
    '{1'b0, 5'd0,  KIND_PUSH, 16'h00ff, 16'h0f0f, 1'b0, NO_REPORT},
    '{1'b0, 5'd0,  KIND_PUSH, 16'h00ff, 16'hf0f0, 1'b0, NO_REPORT},
    '{1'b0, 5'd0,  KIND_PUSH, 16'h0100, 16'h0,    1'b0, NO_REPORT},
    '{1'b0, 5'd0,  KIND_POP,  16'h0,    16'h0,    1'b0, NO_REPORT},
    '{1'b0, 5'd0,  KIND_POP,  16'h0,    16'h0,    1'b0, NO_REPORT},
    '{1'b0, 5'd0,  KIND_POP,  16'h0,    16'h0,    1'b0, NO_REPORT}
  };

  int phase_limits [10] = '{16, 1, 5, 31, 0, 8, 16, 2, 12, 17};

  sorted_priority_queue_top #(
    .DEPTH(DEPTH),
    .PRIO_BITS(PRIO_BITS),
    .TAG_BITS(TAG_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .entry_priority(entry_priority),
    .task_tag(task_tag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .head_valid(head_valid),
    .head_priority(head_priority),
    .head_tag(head_tag),
    .entry_count(entry_count),
    .full_flag(full_flag),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .queue_limit(queue_limit)
  );

  always #1 clk = ~clk;

  function automatic head_report_t apply_queue_op(logic op, logic [PRIO_BITS-1:0] prio,
                                                  logic [TAG_BITS-1:0] tag);
    head_report_t r;
    int           lim;
    int           pos;
    int           i;
    lim = (shadow_limit > DEPTH) ? DEPTH : int'(shadow_limit);
    r = NO_REPORT;
    r.status = ST_DONE;
    if (op == KIND_PUSH) begin
      if (shadow_count >= lim || shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_tag[i]  = shadow_tag[i-1];
        end
        shadow_prio[pos] = prio;
        shadow_tag[pos]  = tag;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        for (i = 1; i < shadow_count; i++) begin
          shadow_prio[i-1] = shadow_prio[i];
          shadow_tag[i-1]  = shadow_tag[i];
        end
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      r.head_valid    = 1'b1;
      r.head_priority = shadow_prio[0];
      r.head_tag      = shadow_tag[0];
    end
    r.entry_count = shadow_count[COUNT_W-1:0];
    r.full_flag   = (shadow_count >= lim);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch_ports
    head_report_t want;
    head_report_t pred;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (head_reports.size() == 0) begin
          $display("%0t: result with no request pending, expected none, actual %0h", $time,
                   {status, head_valid, head_priority, head_tag, entry_count, full_flag});
          fail_count++;
        end else begin
          want = head_reports.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("head_valid", 32'(want.head_valid), 32'(head_valid));
          check_field("head_priority", 32'(want.head_priority), 32'(head_priority));
          check_field("head_tag", 32'(want.head_tag), 32'(head_tag));
          check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
          check_field("full_flag", 32'(want.full_flag), 32'(full_flag));
        end
      end
      if (cfg_valid && cfg_ready) shadow_limit = queue_limit;
      if (in_valid && !in_stall) begin
        pred = apply_queue_op(kind, entry_priority, task_tag);
        head_reports.push_back(typed_pending ? typed_report : pred);
      end
    end
  end

  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int holds_done;
    int beat;
    out_stall = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    holds_done = 0;
    beat = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs > holds_done) begin
        holds_done++;
        hold_left = 80;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (beat % 5 < 3);
        endcase
      end
    end
  end

  task automatic send_req(logic op, logic [PRIO_BITS-1:0] prio, logic [TAG_BITS-1:0] tag,
                          logic typed, head_report_t want);
    @(negedge clk);
    typed_pending = typed;
    typed_report  = want;
    in_valid       <= 1'b1;
    kind           <= op;
    entry_priority <= prio;
    task_tag       <= tag;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (head_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] lim);
    wait_drained();
    @(negedge clk);
    cfg_valid   <= 1'b1;
    queue_limit <= lim;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(int push_pct);
    logic                 op;
    logic [PRIO_BITS-1:0] prio;
    int                   pick;
    op = ($urandom_range(1, 100) <= push_pct) ? KIND_PUSH : KIND_POP;
    pick = $urandom_range(0, 9);
    // narrow range in four picks of ten so equal priorities pile up
    if (pick < 4) prio = PRIO_BITS'($urandom_range(0, 3));
    else if (pick == 8) prio = '0;
    else if (pick == 9) prio = '1;
    else prio = PRIO_BITS'($urandom);
    send_req(op, prio, TAG_BITS'($urandom), 1'b0, NO_REPORT);
  endtask

  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int left;
    int burst;
    int pct;
    rst            = 1'b1;
    in_valid       = 1'b0;
    kind           = KIND_PUSH;
    entry_priority = '0;
    task_tag       = '0;
    cfg_valid      = 1'b0;
    queue_limit    = LIMIT_RESET;
    shadow_count   = 0;
    shadow_limit   = LIMIT_RESET;
    fail_count     = 0;
    hold_reqs      = 0;
    typed_pending  = 1'b0;
    typed_report   = NO_REPORT;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        write_limit(directed_rows[r].limit);
      end else begin
        send_req(directed_rows[r].op, directed_rows[r].prio, directed_rows[r].tag,
                 directed_rows[r].typed, directed_rows[r].want);
        if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 4));
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      write_limit(LIMIT_W'(phase_limits[ph]));
      if (ph == 6) begin
        // output held off long enough for the input side to back up
        hold_reqs++;
        repeat (40) send_random(80);
      end
      left = 185;
      while (left > 0) begin
        burst = $urandom_range(1, 12);
        case ($urandom_range(0, 2))
          0: pct = 85;
          1: pct = 50;
          default: pct = 15;
        endcase
        for (int k = 0; k < burst && left > 0; k++) begin
          send_random(pct);
          left--;
        end
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/spq_pkg.sv
design/spq_front.sv
design/spq_back.sv
design/sorted_priority_queue_top.sv
dv/sorted_priority_queue_top_test.sv
